[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL. Both macros compile to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising edge while reset is released.
`define BMQ_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bmq assertion failed");

// Checked on every rising edge, reset included.
`define BMQ_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("bmq assertion failed");

`else

`define BMQ_ASSERT(label, clk, rst_n, prop)

`define BMQ_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

[hdl/bmq_pkg.sv]
package bmq_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned TASK_W = 4;
  localparam int unsigned FILL_W = 3;

  typedef enum logic {
    OP_SEND = 1'b0,
    OP_RECV = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e             opcode;
    logic [WORD_W-1:0]   send_word;
    logic [TASK_W-1:0]   caller_task;
  } req_t;

  typedef struct packed {
    logic                completed;
    logic [WORD_W-1:0]   recv_word;
    logic                wake_valid;
    logic [TASK_W-1:0]   wake_task;
    logic [FILL_W-1:0]   fill_level;
  } rsp_t;

endpackage

[hdl/bmq_req_if.sv]
interface bmq_req_if;
  logic          valid;
  logic          ready;
  bmq_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/bmq_rsp_if.sv]
interface bmq_rsp_if;
  logic          valid;
  logic          ready;
  bmq_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/bmq_ram.sv]
module bmq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/blocking_message_queue.sv]
// Hardware mailbox on a ring of QUEUE_DEPTH 64-bit words. Every request on req_i
// is a send or a receive and produces exactly one transaction on rsp_o. A send to
// a ring that is not full stores the word; a receive from a ring that is not empty
// returns the oldest word. A request that cannot complete returns completed = 0
// and records the caller as the single waiter of its kind, replacing any earlier
// one; a later completed operation of the opposite kind reports that waiter on
// wake_task. It takes one request per cycle while rsp_o is not stalled and returns
// its result in the cycle after acceptance; the received word comes straight from
// the registered read port of the ring memory, which is only read again when the
// next request is accepted, so the result holds while rsp_o is stalled.
`include "assert_macros.svh"

module blocking_message_queue #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bmq_req_if.sink   req_i,
  bmq_rsp_if.source rsp_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);

  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [OCC_W-1:0] occ_q, occ_d;
  logic             snd_wait_q, snd_wait_d;
  logic [bmq_pkg::TASK_W-1:0] snd_id_q, snd_id_d;
  logic             rcv_wait_q, rcv_wait_d;
  logic [bmq_pkg::TASK_W-1:0] rcv_id_q, rcv_id_d;

  logic out_valid_q, out_valid_d;
  logic done_q, done_d;
  logic recv_sel_q, recv_sel_d;
  logic wake_q, wake_d;
  logic [bmq_pkg::TASK_W-1:0] wake_task_q, wake_task_d;
  logic [bmq_pkg::FILL_W-1:0] fill_q, fill_d;

  logic accept;
  logic is_send;
  logic send_ok;
  logic recv_ok;
  logic [bmq_pkg::WORD_W-1:0] ram_rdata;

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign is_send     = (req_i.data.opcode == bmq_pkg::OP_SEND);
  assign send_ok     = is_send && (occ_q != OCC_FULL);
  assign recv_ok     = !is_send && (occ_q != '0);

  always_comb begin
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    occ_d       = occ_q;
    snd_wait_d  = snd_wait_q;
    snd_id_d    = snd_id_q;
    rcv_wait_d  = rcv_wait_q;
    rcv_id_d    = rcv_id_q;
    done_d      = 1'b0;
    recv_sel_d  = 1'b0;
    wake_d      = 1'b0;
    wake_task_d = '0;
    if (send_ok) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      occ_d    = occ_q + 1'b1;
      done_d   = 1'b1;
      if (rcv_wait_q) begin
        rcv_wait_d  = 1'b0;
        wake_d      = 1'b1;
        wake_task_d = rcv_id_q;
      end
    end else if (recv_ok) begin
      rd_ptr_d   = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      occ_d      = occ_q - 1'b1;
      done_d     = 1'b1;
      recv_sel_d = 1'b1;
      if (snd_wait_q) begin
        snd_wait_d  = 1'b0;
        wake_d      = 1'b1;
        wake_task_d = snd_id_q;
      end
    end else if (is_send) begin
      snd_wait_d = 1'b1;
      snd_id_d   = req_i.data.caller_task;
    end else begin
      rcv_wait_d = 1'b1;
      rcv_id_d   = req_i.data.caller_task;
    end
    fill_d = bmq_pkg::FILL_W'(occ_d);
  end

  always_comb begin
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      occ_q       <= '0;
      snd_wait_q  <= 1'b0;
      snd_id_q    <= '0;
      rcv_wait_q  <= 1'b0;
      rcv_id_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        rd_ptr_q   <= rd_ptr_d;
        wr_ptr_q   <= wr_ptr_d;
        occ_q      <= occ_d;
        snd_wait_q <= snd_wait_d;
        snd_id_q   <= snd_id_d;
        rcv_wait_q <= rcv_wait_d;
        rcv_id_q   <= rcv_id_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      done_q      <= done_d;
      recv_sel_q  <= recv_sel_d;
      wake_q      <= wake_d;
      wake_task_q <= wake_task_d;
      fill_q      <= fill_d;
    end
  end

  // The read is issued only for a completed receive, so the read register keeps
  // the dequeued word until the next transaction is accepted.
  bmq_ram #(
    .WIDTH (bmq_pkg::WORD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (accept && send_ok),
    .waddr_i (wr_ptr_q),
    .wdata_i (req_i.data.send_word),
    .re_i    (accept && recv_ok),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.data.completed  = done_q;
  assign rsp_o.data.recv_word  = recv_sel_q ? ram_rdata : '0;
  assign rsp_o.data.wake_valid = wake_q;
  assign rsp_o.data.wake_task  = wake_task_q;
  assign rsp_o.data.fill_level = fill_q;

  `BMQ_ASSERT(a_occ_bound, clk_i, rst_ni, occ_q <= OCC_FULL)
  `BMQ_ASSERT(a_snd_wait_full, clk_i, rst_ni, snd_wait_q |-> (occ_q == OCC_FULL))
  `BMQ_ASSERT(a_rcv_wait_empty, clk_i, rst_ni, rcv_wait_q |-> (occ_q == '0))
  `BMQ_ASSERT(a_block_records, clk_i, rst_ni, (accept && !send_ok && !recv_ok) |=> (snd_wait_q || rcv_wait_q))
  `BMQ_ASSERT(a_wake_done, clk_i, rst_ni, (out_valid_q && wake_q) |-> done_q)

endmodule

[tb/blocking_message_queue_test.sv]
module blocking_message_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned RANDOM_REQUESTS = 1850;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned HOLD_OFF_CYCLES = 60;

  // One directed request; the expected response is typed in only where fixed is set.
  typedef struct packed {
    bmq_pkg::opcode_e           op;
    logic [bmq_pkg::WORD_W-1:0] word;
    logic [bmq_pkg::TASK_W-1:0] tid;
    logic                       fixed;
    logic                       done;
    logic [bmq_pkg::WORD_W-1:0] rword;
    logic                       wake;
    logic [bmq_pkg::TASK_W-1:0] wtask;
    logic [bmq_pkg::FILL_W-1:0] fill;
  } step_row_t;

  localparam int unsigned NUM_STEPS = 18;
  localparam step_row_t DIRECTED_STEPS [NUM_STEPS] = '{
    '{bmq_pkg::OP_RECV, 64'h0, 4'd3, 1'b1, 1'b0, 64'h0, 1'b0, 4'd0, 3'd0},
    '{bmq_pkg::OP_RECV, 64'h0, 4'd15, 1'b1, 1'b0, 64'h0, 1'b0, 4'd0, 3'd0},
    '{bmq_pkg::OP_SEND, 64'hffff_ffff_ffff_ffff, 4'd0, 1'b1, 1'b1, 64'h0, 1'b1, 4'd15, 3'd1},
    '{bmq_pkg::OP_SEND, 64'h0, 4'd1, 1'b1, 1'b1, 64'h0, 1'b0, 4'd0, 3'd2},
    '{bmq_pkg::OP_SEND, 64'h8000_0000_0000_0001, 4'd2, 1'b0, 1'b0, 64'h0, 1'b0, 4'd0, 3'd0},
    '{bmq_pkg::OP_SEND, 64'h0123_4567_89ab_cdef, 4'd4, 1'b0, 1'b0, 64'h0, 1'b0, 4'd0, 3'd0},
    '{bmq_pkg::OP_SEND, 64'h0000_0000_0000_dead, 4'd5, 1'b1, 1'b0, 64'h0, 1'b0, 4'd0, 3'd4},
    '{bmq_pkg::OP_SEND, 64'h0000_0000_0000_beef, 4'd9, 1'b1, 1'b0, 64'h0, 1'b0, 4'd0, 3'd4},
    '{bmq_pkg::OP_RECV, 64'h0, 4'd6, 1'b1, 1'b1, 64'hffff_ffff_ffff_ffff, 1'b1, 4'd9, 3'd3},
    '{bmq_pkg::OP_SEND, 64'h5555_5555_5555_5555, 4'd7, 1'b0, 1'b0, 64'h0, 1'b0, 4'd0, 3'd0},
    '{bmq_pkg::OP_SEND, 64'haaaa_aaaa_aaaa_aaaa, 4'd8, 1'b0, 1'b0, 64'h0, 1'b0, 4'd0, 3'd0},
    '{bmq_pkg::OP_RECV, 64'h0, 4'd10, 1'b0, 1'b0, 64'h0, 1'b0, 4'd0, 3'd0},
    '{bmq_pkg::OP_RECV, 64'h0, 4'd11, 1'b0, 1'b0, 64'h0, 1'b0, 4'd0, 3'd0},
    '{bmq_pkg::OP_RECV, 64'h0, 4'd12, 1'b0, 1'b0, 64'h0, 1'b0, 4'd0, 3'd0},
    '{bmq_pkg::OP_RECV, 64'hffff_0000_ffff_0000, 4'd13, 1'b0, 1'b0, 64'h0, 1'b0, 4'd0, 3'd0},
    '{bmq_pkg::OP_RECV, 64'h0, 4'd0, 1'b1, 1'b0, 64'h0, 1'b0, 4'd0, 3'd0},
    '{bmq_pkg::OP_SEND, 64'h0, 4'd14, 1'b1, 1'b1, 64'h0, 1'b1, 4'd0, 3'd1},
    '{bmq_pkg::OP_RECV, 64'h0, 4'd15, 1'b0, 1'b0, 64'h0, 1'b0, 4'd0, 3'd0}
  };

  logic clk = 1'b0;
  logic rst_n;

  bmq_req_if req_if ();
  bmq_rsp_if rsp_if ();

  blocking_message_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mailbox shadow state.
  logic [bmq_pkg::WORD_W-1:0] ring_words [DEPTH];
  int unsigned                rd_slot;
  int unsigned                wr_slot;
  int unsigned                held_words;
  logic                       sender_parked;
  logic [bmq_pkg::TASK_W-1:0] sender_tid;
  logic                       receiver_parked;
  logic [bmq_pkg::TASK_W-1:0] receiver_tid;

  bmq_pkg::rsp_t expected_rsps [$];
  int   mismatches;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   stall_requests;

  function automatic bmq_pkg::rsp_t predict_mailbox(bmq_pkg::req_t r);
    bmq_pkg::rsp_t res;
    res = '0;
    if (r.opcode == bmq_pkg::OP_SEND) begin
      if (held_words < DEPTH) begin
        ring_words[wr_slot] = r.send_word;
        wr_slot = (wr_slot + 1) % DEPTH;
        held_words++;
        res.completed = 1'b1;
        if (receiver_parked) begin
          receiver_parked = 1'b0;
          res.wake_valid = 1'b1;
          res.wake_task = receiver_tid;
        end
      end else begin
        sender_parked = 1'b1;
        sender_tid = r.caller_task;
      end
    end else begin
      if (held_words > 0) begin
        res.recv_word = ring_words[rd_slot];
        rd_slot = (rd_slot + 1) % DEPTH;
        held_words--;
        res.completed = 1'b1;
        if (sender_parked) begin
          sender_parked = 1'b0;
          res.wake_valid = 1'b1;
          res.wake_task = sender_tid;
        end
      end else begin
        receiver_parked = 1'b1;
        receiver_tid = r.caller_task;
      end
    end
    res.fill_level = bmq_pkg::FILL_W'(held_words);
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [bmq_pkg::WORD_W-1:0] got,
                             logic [bmq_pkg::WORD_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  function automatic logic [bmq_pkg::WORD_W-1:0] pick_word();
    logic [bmq_pkg::WORD_W-1:0] w;
    case ($urandom_range(7))
      0: w = '0;
      1: w = '1;
      2: w = 64'h1 << $urandom_range(bmq_pkg::WORD_W - 1);
      3: w = ~(64'h1 << $urandom_range(bmq_pkg::WORD_W - 1));
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  // Offers one request, holds it until the transaction completes, then records
  // the response it must produce. Returns at the following falling edge.
  task automatic issue_request(bmq_pkg::req_t r, bit use_fixed, bmq_pkg::rsp_t fixed_rsp);
    bmq_pkg::rsp_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data <= r;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    predicted = predict_mailbox(r);
    expected_rsps.push_back(use_fixed ? fixed_rsp : predicted);
    @(negedge clk);
  endtask

  initial begin : stimulus
    bmq_pkg::req_t r;
    bmq_pkg::rsp_t fixed_rsp;
    step_row_t     row;
    int            burst_left;
    int            send_pct;

    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
    foreach (ring_words[i]) ring_words[i] = '0;
    rd_slot = 0;
    wr_slot = 0;
    held_words = 0;
    sender_parked = 1'b0;
    sender_tid = '0;
    receiver_parked = 1'b0;
    receiver_tid = '0;
    mismatches = 0;
    stall_requests = 0;
    send_idle_pct = 25;
    recv_idle_pct = 52;
    burst_left = 0;
    send_pct = 50;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < NUM_STEPS; i++) begin
      row = DIRECTED_STEPS[i];
      r.opcode = row.op;
      r.send_word = row.word;
      r.caller_task = row.tid;
      fixed_rsp.completed = row.done;
      fixed_rsp.recv_word = row.rword;
      fixed_rsp.wake_valid = row.wake;
      fixed_rsp.wake_task = row.wtask;
      fixed_rsp.fill_level = row.fill;
      issue_request(r, row.fixed, fixed_rsp);
    end

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == 300) stall_requests++;
      if (i == 620) begin
        send_idle_pct = 52;
        recv_idle_pct = 25;
      end
      if (i == 1240) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_requests++;
      end
      // Bursts that lean toward sends or receives drive the ring to full and
      // to empty, so blocking and waking happen often.
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        case ($urandom_range(2))
          0: send_pct = 80;
          1: send_pct = 20;
          default: send_pct = 50;
        endcase
      end
      burst_left--;
      r.opcode = ($urandom_range(99) < send_pct) ? bmq_pkg::OP_SEND : bmq_pkg::OP_RECV;
      r.send_word = pick_word();
      r.caller_task = bmq_pkg::TASK_W'($urandom_range(15));
      issue_request(r, 1'b0, '0);
    end
    req_if.valid <= 1'b0;

    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("blocking_message_queue regression: pass");
    end else begin
      $display("blocking_message_queue regression: fail");
    end
    $finish;
  end

  initial begin : response_drain
    int hold_left;
    int stall_served;
    hold_left = 0;
    stall_served = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_served != stall_requests) begin
        stall_served = stall_requests;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : response_check
    bmq_pkg::rsp_t want;
    if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (expected_rsps.size() == 0) begin
        report_mismatch("response transaction with nothing expected");
      end else begin
        want = expected_rsps.pop_front();
        check_field("completed", 64'(rsp_if.data.completed), 64'(want.completed));
        check_field("recv_word", rsp_if.data.recv_word, want.recv_word);
        check_field("wake_valid", 64'(rsp_if.data.wake_valid), 64'(want.wake_valid));
        check_field("wake_task", 64'(rsp_if.data.wake_task), 64'(want.wake_task));
        check_field("fill_level", 64'(rsp_if.data.fill_level), 64'(want.fill_level));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("blocking_message_queue regression: fail");
    $finish;
  end

endmodule
